@@ rtl/spfh_pkg.sv @@
// Shared types, widths and result codes of the shortest-path frontier heap.
// No dependencies; every other file imports this package.
package spfh_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int HIDX_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = HIDX_W + 1;
  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = 10;
  localparam int WEIGHT_W   = 24;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_SHORTENED   = 3'd1,
    ST_NOT_SHORTER = 3'd2,
    ST_SETTLED     = 3'd3,
    ST_DROPPED     = 3'd4,
    ST_POPPED      = 3'd5,
    ST_EMPTY       = 3'd6
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   hop;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // Per-node word: settled flag and the heap slot the node last moved to.
  typedef struct packed {
    logic              settled;
    logic [HIDX_W-1:0] pos;
  } nmap_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    nmap_t             data;
  } nmap_wr_t;

endpackage

@@ rtl/spfh_node_map.sv @@
// Node map: settled flag and heap slot for every node, one synchronous memory.
// Sweeps itself to zero after reset. Depends on spfh_pkg.
module spfh_node_map import spfh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [NODE_W-1:0] rd_addr,
  output nmap_t             rd_data,
  input  nmap_wr_t          wr,
  output logic              clearing
);

  nmap_t             mem [NODE_COUNT];
  logic [NODE_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == NODE_W'(NODE_COUNT - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/shortest_path_frontier_heap_core.sv @@
// Frontier queue of a shortest-path search: binary min-heap with decrease-key.
// Depends on spfh_pkg and spfh_node_map.
//
// Issue an item by raising start while busy is low: mode 0 offers (node, next_hop,
// weight), mode 1 pops the minimum and settles its node. Exactly one result per
// item comes back on done for one cycle and cannot be held off, so take it then.
// After reset, busy stays high while the node map is swept clear.
// The heap entries sit in a 256-deep memory and a 1024-deep node map records
// each node's slot and settled flag, so finding a queued node costs two reads.
// The heap memory's single read port sets the pace: an offer that changes nothing
// reads the map and then the heap slot, one that places an entry then rises, reading
// the parent per level; a pop that empties the heap stops at the root, otherwise
// it moves the last entry to the root and sinks it, reading both children per level.
module shortest_path_frontier_heap_core import spfh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic [NODE_W-1:0]   node,
  input  logic [NODE_W-1:0]   next_hop,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                done,
  output logic [2:0]          status,
  output logic [NODE_W-1:0]   out_node,
  output logic [NODE_W-1:0]   out_next_hop,
  output logic [WEIGHT_W-1:0] out_weight,
  output logic [CNT_W-1:0]    queued_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_OFF_POS, S_OFF_CHK, S_UP, S_UP_CMP,
    S_POP_ROOT, S_POP_LAST, S_DN, S_DN_L, S_DN_R
  } state_t;

  state_t              state;
  status_t             code;
  status_t             status_r;
  logic [CNT_W-1:0]    count;
  logic [HIDX_W-1:0]   hole;
  entry_t              item;
  entry_t              left;
  logic [NODE_W-1:0]   node_r;
  logic [NODE_W-1:0]   hop_r;
  logic [WEIGHT_W-1:0] weight_r;

  // heap memory
  entry_t            heap_mem [HEAP_DEPTH];
  entry_t            hrd;
  logic [HIDX_W-1:0] h_raddr;
  logic              h_we;
  logic [HIDX_W-1:0] h_waddr;
  entry_t            h_wdata;

  // node map
  logic [NODE_W-1:0] m_raddr;
  nmap_t             mrd;
  nmap_wr_t          m_wr;
  logic              clearing;

  logic [HIDX_W-1:0] parent_idx;
  logic [CNT_W-1:0]  lchild;
  logic [HIDX_W-1:0] rchild;
  logic              take_left;
  entry_t            small_e;
  logic              found;

  spfh_node_map u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (m_raddr),
    .rd_data  (mrd),
    .wr       (m_wr),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_waddr] <= h_wdata;
    hrd <= heap_mem[h_raddr];
  end

  assign parent_idx = (hole - 1'b1) >> 1;
  assign lchild     = {hole, 1'b1};
  assign rchild     = lchild[HIDX_W-1:0] + 1'b1;
  // tie goes to the right child
  assign take_left  = hrd.weight > left.weight;
  assign small_e    = take_left ? left : hrd;
  // a slot read from the map is trusted only if it is live and holds this node
  assign found      = ({1'b0, mrd.pos} < count) && (hrd.node == node_r);

  assign busy         = (state != S_IDLE) || clearing;
  assign status       = status_r;
  assign queued_count = count;

  // Memory addressing: read what the next state compares, write the hole.
  always_comb begin
    h_raddr     = '0;
    h_we        = 1'b0;
    h_waddr     = hole;
    h_wdata     = item;
    m_raddr     = node_r;
    m_wr.en     = 1'b0;
    m_wr.addr   = item.node;
    m_wr.data   = '{settled: 1'b0, pos: hole};
    case (state)
      S_IDLE: begin
        m_raddr = node;
      end
      S_OFF_POS: begin
        h_raddr = mrd.pos;
      end
      S_UP: begin
        if (hole == '0) begin
          h_we    = 1'b1;
          m_wr.en = 1'b1;
        end else begin
          h_raddr = parent_idx;
        end
      end
      S_UP_CMP: begin
        h_we    = 1'b1;
        m_wr.en = 1'b1;
        if (item.weight < hrd.weight) begin
          h_wdata   = hrd;
          m_wr.addr = hrd.node;
        end
      end
      S_POP_ROOT: begin
        // settle the popped node
        m_wr.en   = 1'b1;
        m_wr.addr = hrd.node;
        m_wr.data = '{settled: 1'b1, pos: '0};
        h_raddr   = HIDX_W'(count - 1'b1);
      end
      S_DN: begin
        if (lchild >= count) begin
          h_we    = 1'b1;
          m_wr.en = 1'b1;
        end else begin
          h_raddr = lchild[HIDX_W-1:0];
        end
      end
      S_DN_L: begin
        h_raddr = rchild;
        if (lchild == count - 1'b1) begin
          h_we    = 1'b1;
          m_wr.en = 1'b1;
          if (item.weight > hrd.weight) begin
            h_wdata   = hrd;
            m_wr.addr = hrd.node;
          end
        end
      end
      S_DN_R: begin
        h_we    = 1'b1;
        m_wr.en = 1'b1;
        if (item.weight > small_e.weight) begin
          h_wdata   = small_e;
          m_wr.addr = small_e.node;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            node_r       <= node;
            hop_r        <= next_hop;
            weight_r     <= weight;
            out_node     <= '0;
            out_next_hop <= '0;
            out_weight   <= '0;
            if (!mode) begin
              state <= S_OFF_POS;
            end else if (count == '0) begin
              done     <= 1'b1;
              status_r <= ST_EMPTY;
            end else begin
              state <= S_POP_ROOT;
            end
          end
        end
        S_OFF_POS: begin
          state <= S_OFF_CHK;
        end
        S_OFF_CHK: begin
          item <= '{node: node_r, hop: hop_r, weight: weight_r};
          if (found) begin
            if (weight_r < hrd.weight) begin
              hole  <= mrd.pos;
              code  <= ST_SHORTENED;
              state <= S_UP;
            end else begin
              done     <= 1'b1;
              status_r <= ST_NOT_SHORTER;
              state    <= S_IDLE;
            end
          end else if (mrd.settled) begin
            done     <= 1'b1;
            status_r <= ST_SETTLED;
            state    <= S_IDLE;
          end else if (count == CNT_W'(HEAP_DEPTH)) begin
            done     <= 1'b1;
            status_r <= ST_DROPPED;
            state    <= S_IDLE;
          end else begin
            hole  <= count[HIDX_W-1:0];
            count <= count + 1'b1;
            code  <= ST_INSERTED;
            state <= S_UP;
          end
        end
        S_UP: begin
          if (hole == '0) begin
            done     <= 1'b1;
            status_r <= code;
            state    <= S_IDLE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (item.weight < hrd.weight) begin
            hole  <= parent_idx;
            state <= S_UP;
          end else begin
            done     <= 1'b1;
            status_r <= code;
            state    <= S_IDLE;
          end
        end
        S_POP_ROOT: begin
          out_node     <= hrd.node;
          out_next_hop <= hrd.hop;
          out_weight   <= hrd.weight;
          count        <= count - 1'b1;
          code         <= ST_POPPED;
          if (count == CNT_W'(1)) begin
            done     <= 1'b1;
            status_r <= ST_POPPED;
            state    <= S_IDLE;
          end else begin
            state <= S_POP_LAST;
          end
        end
        S_POP_LAST: begin
          item  <= hrd;
          hole  <= '0;
          state <= S_DN;
        end
        S_DN: begin
          if (lchild >= count) begin
            done     <= 1'b1;
            status_r <= code;
            state    <= S_IDLE;
          end else begin
            state <= S_DN_L;
          end
        end
        S_DN_L: begin
          left <= hrd;
          if (lchild == count - 1'b1) begin
            if (item.weight > hrd.weight) begin
              hole  <= lchild[HIDX_W-1:0];
              state <= S_DN;
            end else begin
              done     <= 1'b1;
              status_r <= code;
              state    <= S_IDLE;
            end
          end else begin
            state <= S_DN_R;
          end
        end
        S_DN_R: begin
          if (item.weight > small_e.weight) begin
            hole  <= take_left ? lchild[HIDX_W-1:0] : rchild;
            state <= S_DN;
          end else begin
            done     <= 1'b1;
            status_r <= code;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode && (count == '0) |=> done && (status_r == ST_EMPTY))
    else $error("empty extract not answered at once");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy)
    else $error("item accepted during map clear");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    done && (status_r == ST_DROPPED) |-> count == CNT_W'(HEAP_DEPTH))
    else $error("offer dropped while heap not full");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_ROOT) |=> count == $past(count) - 1'b1)
    else $error("pop did not shrink heap");

endmodule
